// ----- hw/rtl/bs_pkg.sv -----
// Shared types and constants for the bubble sorter.
package bs_pkg;

  localparam int MAX_ITEMS_DEF = 16;
  localparam int DATA_W        = 32;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_SETUP,
    ST_RD0,
    ST_CUR,
    ST_CMP,
    ST_WB,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic store;     // accept an input beat
    logic setup;     // load pass limit from count
    logic rd0;       // read entry 0 to start a pass
    logic load_cur;  // latch entry 0, read entry 1
    logic cmp;       // compare-swap one adjacent pair
    logic wb;        // write back the pass maximum
    logic emit_rd;   // read the next sorted entry
    logic emit_ld;   // load the output register
  } cmd_t;

  typedef struct packed {
    logic small_set;  // fewer than two values held
    logic step_last;  // last pair of this pass
    logic lim_last;   // last pass
    logic emit_last;  // entry being emitted is the last
    logic out_free;   // output register empty or draining
  } stat_t;

endpackage

// ----- hw/rtl/bs_ctrl.sv -----
// Sequencer for collecting, sorting and emitting one set.
module bs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  bs_pkg::stat_t stat,
  output bs_pkg::cmd_t  cmd
);

  bs_pkg::state_t state;
  bs_pkg::state_t state_next;
  logic           accept;

  assign accept = in_valid && (state == bs_pkg::ST_COLLECT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bs_pkg::ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bs_pkg::ST_COLLECT: begin
        if (accept && in_last) state_next = bs_pkg::ST_SETUP;
      end
      bs_pkg::ST_SETUP: begin
        state_next = stat.small_set ? bs_pkg::ST_EMIT_RD : bs_pkg::ST_RD0;
      end
      bs_pkg::ST_RD0: begin
        state_next = bs_pkg::ST_CUR;
      end
      bs_pkg::ST_CUR: begin
        state_next = bs_pkg::ST_CMP;
      end
      bs_pkg::ST_CMP: begin
        if (stat.step_last) state_next = bs_pkg::ST_WB;
      end
      bs_pkg::ST_WB: begin
        state_next = stat.lim_last ? bs_pkg::ST_EMIT_RD : bs_pkg::ST_RD0;
      end
      bs_pkg::ST_EMIT_RD: begin
        if (stat.out_free) state_next = bs_pkg::ST_EMIT_LD;
      end
      bs_pkg::ST_EMIT_LD: begin
        state_next = stat.emit_last ? bs_pkg::ST_COLLECT : bs_pkg::ST_EMIT_RD;
      end
      default: begin
        state_next = bs_pkg::ST_COLLECT;
      end
    endcase
  end

  always_comb begin
    in_ready     = (state == bs_pkg::ST_COLLECT);
    cmd          = '0;
    cmd.store    = accept;
    cmd.setup    = (state == bs_pkg::ST_SETUP);
    cmd.rd0      = (state == bs_pkg::ST_RD0);
    cmd.load_cur = (state == bs_pkg::ST_CUR);
    cmd.cmp      = (state == bs_pkg::ST_CMP);
    cmd.wb       = (state == bs_pkg::ST_WB);
    cmd.emit_rd  = (state == bs_pkg::ST_EMIT_RD) && stat.out_free;
    cmd.emit_ld  = (state == bs_pkg::ST_EMIT_LD);
  end

endmodule

// ----- hw/rtl/bs_datapath.sv -----
// Value store, compare-swap unit, counters and output register.
module bs_datapath #(
  parameter int MAX_ITEMS = bs_pkg::MAX_ITEMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bs_pkg::cmd_t                     cmd,
  output bs_pkg::stat_t                    stat,
  input  logic signed [bs_pkg::DATA_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [bs_pkg::DATA_W-1:0] out_value,
  output logic                             out_last,
  output logic                             out_ovf
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic signed [bs_pkg::DATA_W-1:0] mem [MAX_ITEMS];
  logic signed [bs_pkg::DATA_W-1:0] rdata;
  logic signed [bs_pkg::DATA_W-1:0] cur;
  logic signed [bs_pkg::DATA_W-1:0] lo;
  logic signed [bs_pkg::DATA_W-1:0] hi;
  logic signed [bs_pkg::DATA_W-1:0] wdata;
  logic [CW-1:0] count;
  logic [CW-1:0] k;
  logic [CW-1:0] lim;
  logic          ovf;
  logic          full;
  logic          swap;
  logic [CW-1:0] raddr_full;
  logic [CW-1:0] waddr_full;
  logic          rd_en;
  logic          wr_en;

  assign full = (count == CW'(MAX_ITEMS));
  assign swap = (cur > rdata);
  assign lo   = swap ? rdata : cur;
  assign hi   = swap ? cur : rdata;

  always_comb begin
    stat.small_set = (count < CW'(2));
    stat.step_last = ((k + CW'(1)) == lim);
    stat.lim_last  = (lim == CW'(1));
    stat.emit_last = ((k + CW'(1)) == count);
    stat.out_free  = !out_valid || out_ready;
  end

  // Single read port: pass start, pair fetch ahead, or emit.
  always_comb begin
    raddr_full = k;
    if (cmd.rd0) begin
      raddr_full = '0;
    end else if (cmd.load_cur) begin
      raddr_full = k + CW'(1);
    end else if (cmd.cmp) begin
      raddr_full = k + CW'(2);
    end
    rd_en = cmd.rd0 || cmd.load_cur || (cmd.cmp && !stat.step_last) || cmd.emit_rd;
  end

  // Single write port: incoming value, lower of a pair, or pass maximum.
  always_comb begin
    waddr_full = count;
    wdata      = in_value;
    wr_en      = cmd.store && !full;
    if (cmd.cmp) begin
      waddr_full = k;
      wdata      = lo;
      wr_en      = 1'b1;
    end else if (cmd.wb) begin
      waddr_full = lim;
      wdata      = cur;
      wr_en      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr_full[AW-1:0]] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr_full[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      k         <= '0;
      lim       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.store) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.emit_ld && stat.emit_last) begin
        count <= '0;
        ovf   <= 1'b0;
      end
      if (cmd.setup || cmd.wb || cmd.rd0) begin
        k <= '0;
      end else if (cmd.cmp || cmd.emit_ld) begin
        k <= k + CW'(1);
      end
      if (cmd.setup) begin
        lim <= count - CW'(1);
      end else if (cmd.wb) begin
        lim <= lim - CW'(1);
      end
      if (cmd.emit_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cur) begin
      cur <= rdata;
    end else if (cmd.cmp) begin
      cur <= hi;
    end
    if (cmd.emit_ld) begin
      out_value <= rdata;
      out_last  <= stat.emit_last;
      out_ovf   <= stat.emit_last && ovf;
    end
  end

endmodule

// ----- hw/rtl/bubble_sorter.sv -----
// Top level of the bubble sorter: collects a set, sorts it, streams it out.
// Input: one beat per cycle while collecting; a set of N stored values
// (N up to MAX_ITEMS) is then sorted by the single compare-swap unit
// through the one read port of the store, and no new set is taken until
// its last sorted value has been loaded into the output register.
// Reset (rst, synchronous, active high) empties the set and the output.
module bubble_sorter #(
  parameter int MAX_ITEMS = bs_pkg::MAX_ITEMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream: tdata = sample_value[31:0]; tlast = final_item
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  // Output stream: tdata = sorted_value[31:0]; tlast = run_end;
  // tuser = overflowed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tuser
);

  bs_pkg::cmd_t  cmd;
  bs_pkg::stat_t stat;

  logic signed [bs_pkg::DATA_W-1:0] out_value;

  // Sequencer: owns the input handshake and steps the datapath through
  // collect, the shrinking bubble passes, and the emit loop.
  bs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: indexed store, running pass maximum, count and overflow flag,
  // and the output register that holds a beat until the sink takes it.
  bs_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_value  ($signed(s_axis_tdata)),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (out_value),
    .out_last  (m_axis_tlast),
    .out_ovf   (m_axis_tuser)
  );

  assign m_axis_tdata = $unsigned(out_value);

endmodule

// ----- tb/tb_bubble_sorter.sv -----
// Testbench for the bubble sorter: directed and random sets in, sorted beats checked against a predictor.
`timescale 1ns / 1ps

module tb_bubble_sorter;

  localparam int CAP            = bs_pkg::MAX_ITEMS_DEF;
  localparam int DW             = bs_pkg::DATA_W;
  localparam int DIRECTED_ITEMS = 24;
  localparam int RANDOM_ITEMS   = 320;
  localparam int IDLE_PCT       = 27;
  localparam int HOLD_CYCLES    = 600;
  localparam int DRAIN_CYCLES   = 400;
  localparam int CYCLE_LIMIT    = 400000;

  // Holds the set being collected, sorts it on the final beat and queues the
  // sorted beats that the block must emit.
  class sort_checker;
    typedef struct {
      logic [DW-1:0] value;
      logic          run_end;
      logic          ovf;
    } sorted_beat_t;

    sorted_beat_t  expected_sorted[$];
    logic [DW-1:0] held[CAP];
    int            held_count;
    bit            dropped;
    int            mismatches;

    function new();
      held_count = 0;
      dropped    = 0;
      mismatches = 0;
    endfunction

    function void note_beat(logic [DW-1:0] value, logic last);
      logic [DW-1:0] t;
      sorted_beat_t  b;
      int            n;
      if (held_count < CAP) begin
        held[held_count] = value;
        held_count++;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      n = held_count;
      for (int pass = 0; pass + 1 < n; pass++) begin
        for (int k = 0; k + 1 < n - pass; k++) begin
          if ($signed(held[k]) > $signed(held[k+1])) begin
            t         = held[k];
            held[k]   = held[k+1];
            held[k+1] = t;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        b.value   = held[k];
        b.run_end = (k == n - 1);
        b.ovf     = (k == n - 1) ? dropped : 1'b0;
        expected_sorted.push_back(b);
      end
      held_count = 0;
      dropped    = 0;
    endfunction

    function void check_beat(logic [DW-1:0] value, logic last, logic ovf);
      sorted_beat_t want;
      if (expected_sorted.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: data=%h last=%b user=%b", value, last, ovf);
        return;
      end
      want = expected_sorted.pop_front();
      if (want.value !== value || want.run_end !== last || want.ovf !== ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output beat mismatch: expected data=%h last=%b user=%b, got data=%h last=%b user=%b",
                   want.value, want.run_end, want.ovf, value, last, ovf);
      end
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [DW-1:0] s_axis_tdata;
  logic          s_axis_tlast;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [DW-1:0] m_axis_tdata;
  logic          m_axis_tlast;
  logic          m_axis_tuser;

  // Random idling on each side; both drop to zero for a stretch of sets.
  logic src_gaps;
  logic sink_gaps;
  // Long sink hold-off, run by its own process once hold_go rises.
  logic hold_go;
  logic hold_sink;

  int   cycle_count;

  sort_checker sb = new();

  bubble_sorter #(
    .MAX_ITEMS(CAP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    // tdata = sample_value[31:0]; tlast = final_item
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    // tdata = sorted_value[31:0]; tlast = run_end; tuser = overflowed
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one input beat, after a random gap, and hold it until accepted.
  // Signals read right after the edge still carry their pre-edge values.
  task automatic send_beat(input logic [DW-1:0] value, input logic last);
    while (src_gaps && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_beat(value, last);
  endtask

  // Pick a value: full random words, a narrow range to force ties, or extremes.
  function automatic logic [DW-1:0] pick_value(int mode);
    logic [DW-1:0] v;
    case (mode)
      0: v = $urandom;
      1: v = $urandom_range(6) - 3;
      default: begin
        case ($urandom_range(5))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          4: v = 32'h0000_0001;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  // Stimulus: reset, directed sets, then random sets; drain and report.
  initial begin
    int sent;
    int set_idx;
    int set_size;
    int mode;
    int r;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    src_gaps      <= 1'b1;
    sink_gaps     <= 1'b1;
    hold_go       <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Single-value set at the most negative value.
    send_beat(32'h8000_0000, 1'b1);
    // Two extremes, in the wrong order.
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'h8000_0000, 1'b1);
    // Ties around zero.
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b0);
    send_beat(32'h0000_0000, 1'b1);
    // Overfull set: the last two beats, the final one included, are dropped.
    for (int i = 0; i < 18; i++)
      send_beat((i % 2 == 0) ? 32'h7FFF_FFFF - i : 32'h8000_0000 + i, i == 17);

    sent    = DIRECTED_ITEMS;
    set_idx = 0;
    while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 8)       set_size = $urandom_range(CAP + 4, CAP + 1);
      else if (r < 16) set_size = CAP;
      else if (r < 26) set_size = 1;
      else             set_size = $urandom_range(12, 2);
      mode = $urandom_range(2);

      // Turn idling off for a run of sets in the middle.
      if (set_idx >= 12 && set_idx < 20) begin
        src_gaps  <= 1'b0;
        sink_gaps <= 1'b0;
      end else begin
        src_gaps  <= 1'b1;
        sink_gaps <= 1'b1;
      end
      if (set_idx == 3)
        hold_go <= 1'b1;

      for (int j = 0; j < set_size; j++)
        send_beat(pick_value(mode), j == set_size - 1);
      sent += set_size;
      set_idx++;
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_sorted.size() == 0) begin
      $display("tb_bubble_sorter: done, clean");
    end else begin
      $display("tb_bubble_sorter: done, errors");
    end
    $finish;
  end

  // Sink: check each accepted output beat, then pick tready for the next edge.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if (hold_sink)
        m_axis_tready <= 1'b0;
      else if (sink_gaps && $urandom_range(99) < IDLE_PCT)
        m_axis_tready <= 1'b0;
      else
        m_axis_tready <= 1'b1;
    end
  end

  // Hold the sink off long enough for the block to fill and stall its input.
  initial begin
    hold_sink <= 1'b0;
    @(posedge clk);
    while (!hold_go) @(posedge clk);
    hold_sink <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_sink <= 1'b0;
  end

  // Watchdog: end the run if it has not finished by the cycle limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_bubble_sorter: done, errors");
    $finish;
  end

endmodule
